@@ rtl/bpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bpt_pkg: shared types and constants for the pairing tracker
// Event codes, method codes, phases, table sizes and the method lookup.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int CONN_ENTRIES   = 16;
  localparam int PAIRED_ENTRIES = 64;
  localparam int CONN_IW        = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
  localparam int PAIR_IW        = (PAIRED_ENTRIES > 1) ? $clog2(PAIRED_ENTRIES) : 1;
  localparam int PAIR_CW        = $clog2(PAIRED_ENTRIES + 1);

  localparam logic [2:0] EV_CONN     = 3'd0;
  localparam logic [2:0] EV_DISC     = 3'd1;
  localparam logic [2:0] EV_ENC      = 3'd2;
  localparam logic [2:0] EV_PAIR_REQ = 3'd3;
  localparam logic [2:0] EV_PAIR_RSP = 3'd4;
  localparam logic [2:0] EV_PAIR_FAIL = 3'd5;

  localparam logic [2:0] M_JW  = 3'd0;
  localparam logic [2:0] M_PK  = 3'd1;
  localparam logic [2:0] M_NC  = 3'd2;
  localparam logic [2:0] M_OOB = 3'd3;
  localparam logic [2:0] M_UNK = 3'd4;

  localparam logic [1:0] PH_CONN = 2'd0;
  localparam logic [1:0] PH_REQ  = 2'd1;
  localparam logic [1:0] PH_RESP = 2'd2;

  localparam logic [7:0] AUTH_SC   = 8'b0000_1000;
  localparam logic [7:0] AUTH_MITM = 8'b0000_0100;
  localparam logic [7:0] IO_MAX    = 8'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [47:0] adapter_addr;
    logic [63:0] timestamp;
    logic [11:0] handle;
    logic [7:0]  status;
    logic [47:0] peer_addr;
    logic [7:0]  io_capability;
    logic [7:0]  oob_flag;
    logic [7:0]  auth_req;
  } in_item_t;

  typedef struct packed {
    logic [63:0] alert_time;
    logic [47:0] device_addr;
    logic [47:0] alert_adapter;
    logic        repeated_pairing;
    logic        pair_success;
    logic        pair_version;
    logic [2:0]  pair_method;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture input item, look up connection
    logic apply;     // apply table update for the event
    logic scan_clr;  // reset paired-table scan
    logic scan_step; // examine one paired entry
    logic record;    // write new paired entry
    logic emit;      // load output register
  } bpt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       need_alert;
    logic       scan_done;
    logic       can_record;
  } bpt_sts_t;

  // Association method from the spec tables, rows by responder, columns by initiator.
  function automatic logic [2:0] tab_method(input logic sc, input logic [2:0] rs,
                                            input logic [2:0] rq);
    logic [2:0] m;
    m = M_PK;
    if (rs == 3'd3 || rq == 3'd3) m = M_JW;
    else if ((rs == 3'd0 || rs == 3'd1) && (rq == 3'd0 || rq == 3'd1)) begin
      m = (sc && rs == 3'd1 && rq == 3'd1) ? M_NC : M_JW;
    end else if (sc && (rs == 3'd1 || rs == 3'd4) && (rq == 3'd1 || rq == 3'd4)) begin
      m = M_NC;
    end
    return m;
  endfunction

endpackage

@@ rtl/bpt_if.sv @@
// ----------------------------------------------------------------------------
// bpt_in_if / bpt_out_if: valid-ready channels of the pairing tracker
// Each carries valid, ready and the item payload.
// ----------------------------------------------------------------------------
interface bpt_in_if import bpt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bpt_out_if import bpt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpt_ctrl: sequencing of one event
// Accepts an item, applies it and, when the event needs an alert, scans the paired table and raises it.
// ----------------------------------------------------------------------------
module bpt_ctrl import bpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bpt_cmd_t cmd,
  input  bpt_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_APPLY, S_SCAN, S_REC, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // Lookup result is registered; the event now acts on the tables.
        cmd.apply    = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.need_alert ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_REC;
      end
      S_REC: begin
        // The output register may still hold the previous alert.
        if (!out_valid_r || out_ready) begin
          cmd.record    = sts.can_record;
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/bpt_dp.sv @@
// ----------------------------------------------------------------------------
// bpt_dp: connection table, paired table and alert datapath
// Holds per-handle state, the paired-pair memory and the output register.
// ----------------------------------------------------------------------------
module bpt_dp import bpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  bpt_cmd_t  cmd,
  output bpt_sts_t  sts,
  output out_item_t out_data
);

  logic [CONN_ENTRIES-1:0] cv_r;
  logic [11:0] tag_r   [CONN_ENTRIES];
  logic [47:0] peer_r  [CONN_ENTRIES];
  logic [1:0]  phase_r [CONN_ENTRIES];
  logic [10:0] info_r  [CONN_ENTRIES];
  logic [3:0]  vm_r    [CONN_ENTRIES];

  logic [95:0]         pmem [PAIRED_ENTRIES];
  logic [95:0]         prd_r;
  logic [PAIR_CW-1:0]  pcnt_r;   // entries fill in order, none is freed
  logic [PAIR_CW-1:0]  sidx_r;
  logic                rd_vld_r;
  logic                rep_r;

  in_item_t            it_r;
  logic                hit_r, free_ok_r;
  logic [CONN_IW-1:0]  e_r, free_r;
  logic                alert_r, ok_r;
  logic [47:0]         dev_r;
  logic [3:0]          avm_r;
  out_item_t           out_r;

  // Handle lookup and first free slot over the small connection table.
  logic               hit_c, free_ok_c;
  logic [CONN_IW-1:0] e_c, free_c;
  always_comb begin
    hit_c = 1'b0; e_c = '0; free_ok_c = 1'b0; free_c = '0;
    for (int i = CONN_ENTRIES - 1; i >= 0; i--) begin
      if (cv_r[i] && tag_r[i] == in_data.handle) begin
        hit_c = 1'b1; e_c = CONN_IW'(i);
      end
      if (!cv_r[i]) begin
        free_ok_c = 1'b1; free_c = CONN_IW'(i);
      end
    end
  end

  logic [10:0] rs_info, rq_info;
  logic        sc_c, oob_c;
  logic [2:0]  meth_c;
  always_comb begin
    rs_info = {(it_r.auth_req & AUTH_SC) != 8'd0, (it_r.auth_req & AUTH_MITM) != 8'd0,
               it_r.oob_flag == 8'd1, it_r.io_capability};
    rq_info = info_r[e_r];
    sc_c    = rq_info[10] && rs_info[10];
    oob_c   = sc_c ? (rq_info[8] || rs_info[8]) : (rq_info[8] && rs_info[8]);
    if (oob_c) meth_c = M_OOB;
    else if (!rq_info[9] && !rs_info[9]) meth_c = M_JW;
    else if (rq_info[7:0] > IO_MAX || rs_info[7:0] > IO_MAX) meth_c = M_UNK;
    else meth_c = tab_method(sc_c, rs_info[2:0], rq_info[2:0]);
  end

  logic phase_is_conn, phase_is_resp, ev_alert, ev_ok;
  always_comb begin
    phase_is_conn = phase_r[e_r] == PH_CONN;
    phase_is_resp = phase_r[e_r] == PH_RESP;
    ev_alert = 1'b0;
    ev_ok    = 1'b0;
    case (it_r.req_type)
      EV_DISC:      ev_alert = hit_r && !phase_is_conn;
      EV_ENC: begin
        ev_alert = hit_r && phase_is_resp;
        ev_ok    = it_r.status == 8'd0;
      end
      EV_PAIR_FAIL: ev_alert = hit_r;
      default:      ev_alert = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r   <= '0;
      pcnt_r <= '0;
    end else begin
      if (cmd.apply) begin
        case (it_r.req_type)
          EV_CONN: if (it_r.status == 8'd0 && !hit_r && free_ok_r) cv_r[free_r] <= 1'b1;
          EV_DISC: if (hit_r) cv_r[e_r] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.record) pcnt_r <= pcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r      <= in_data;
      hit_r     <= hit_c;
      e_r       <= e_c;
      free_ok_r <= free_ok_c;
      free_r    <= free_c;
    end
    if (cmd.apply) begin
      alert_r <= ev_alert;
      ok_r    <= ev_ok;
      dev_r   <= peer_r[e_r];
      avm_r   <= vm_r[e_r];
      case (it_r.req_type)
        EV_CONN: if (it_r.status == 8'd0 && !hit_r && free_ok_r) begin
          tag_r[free_r]   <= it_r.handle;
          peer_r[free_r]  <= it_r.peer_addr;
          phase_r[free_r] <= PH_CONN;
          info_r[free_r]  <= '0;
          vm_r[free_r]    <= {1'b0, M_UNK};
        end
        EV_ENC:       if (hit_r && phase_is_resp) phase_r[e_r] <= PH_CONN;
        EV_PAIR_REQ:  if (hit_r) begin
          phase_r[e_r] <= PH_REQ;
          info_r[e_r]  <= rs_info;
        end
        EV_PAIR_RSP:  if (hit_r) begin
          phase_r[e_r] <= PH_RESP;
          vm_r[e_r]    <= {sc_c, meth_c};
        end
        EV_PAIR_FAIL: if (hit_r) phase_r[e_r] <= PH_CONN;
        default: ;
      endcase
    end
  end

  // Paired table scan: one memory read per cycle, compare on the registered word.
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      sidx_r   <= '0;
      rd_vld_r <= 1'b0;
      rep_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      if (sidx_r < pcnt_r) begin
        prd_r  <= pmem[sidx_r[PAIR_IW-1:0]];
        sidx_r <= sidx_r + 1'b1;
        rd_vld_r <= 1'b1;
      end else begin
        rd_vld_r <= 1'b0;
      end
      if (rd_vld_r && prd_r == {it_r.adapter_addr, dev_r}) rep_r <= 1'b1;
    end
    if (cmd.record) pmem[pcnt_r[PAIR_IW-1:0]] <= {it_r.adapter_addr, dev_r};
    if (cmd.emit) begin
      out_r.alert_time       <= it_r.timestamp;
      out_r.device_addr      <= dev_r;
      out_r.alert_adapter    <= it_r.adapter_addr;
      out_r.repeated_pairing <= rep_r;
      out_r.pair_success     <= ok_r;
      out_r.pair_version     <= avm_r[3];
      out_r.pair_method      <= avm_r[2:0];
    end
  end

  assign sts.need_alert = ev_alert;
  assign sts.scan_done  = (sidx_r >= pcnt_r) && !rd_vld_r;
  assign sts.can_record = ok_r && !rep_r && (pcnt_r < PAIR_CW'(PAIRED_ENTRIES));
  assign out_data       = out_r;

endmodule

@@ rtl/ble_pairing_tracker_core.sv @@
// ----------------------------------------------------------------------------
// ble_pairing_tracker_core: BLE pairing tracker top level
// Tracks connections and pairing, and raises pairing alerts.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_ch   | sink      | link event item (in_item_t)
// out_ch  | source    | pairing alert item (out_item_t)
//
// An event is taken in the idle step and applied to the tables; an event without an
// alert then returns to idle. An alert goes on to scan every recorded paired entry,
// one memory read per cycle, then records a new paired entry where allowed and emits
// the alert in its final step. Reset is synchronous and clears the valid bits and the
// paired fill count. A stalled alert holds the block in its final step until the output register frees.
module ble_pairing_tracker_core import bpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bpt_in_if.sink    in_ch,
  bpt_out_if.source out_ch
);

  bpt_cmd_t cmd;
  bpt_sts_t sts;

  bpt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  bpt_dp u_dp (
    .clk, .rst_n,
    .in_data (in_ch.data), .cmd, .sts, .out_data(out_ch.data)
  );

endmodule

@@ rtl/bpt_checker.sv @@
// ----------------------------------------------------------------------------
// bpt_checker: port-level checks for the pairing tracker
// Bound to the top level; watches the channels only.
// ----------------------------------------------------------------------------
module bpt_checker import bpt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("alert dropped or changed while stalled");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first was applied");

  a_method: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pair_method <= M_UNK)
    else $error("alert method code out of range");

endmodule

bind ble_pairing_tracker_core bpt_checker u_bpt_checker (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
